/* rtl/core/sigmoid_neuron_sgd_top_assert.svh */
// assertion macros for the sigmoid neuron block
// used by the port checker, no other dependencies
`ifndef SIGMOID_NEURON_SGD_TOP_ASSERT_SVH
`define SIGMOID_NEURON_SGD_TOP_ASSERT_SVH

// clocked assertion, held off while reset is low
`define SNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, checked during reset as well
`define SNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/sns_pkg.sv */
// shared types, constants and the sigmoid lookup table for the neuron block
// no dependencies
`default_nettype none

package sns_pkg;

    localparam int NUM_INPUTS = 16;
    localparam int IDX_W      = $clog2(NUM_INPUTS);
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);

    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint E1_Q30  = 64'sd395007542;

    localparam logic [12:0] ONE_Q12 = 13'd4096;

    typedef enum logic [2:0] {
        CMD_FWD       = 3'd0,
        CMD_TRAIN_ERR = 3'd1,
        CMD_TRAIN_TGT = 3'd2,
        CMD_LOAD_W    = 3'd3,
        CMD_LOAD_B    = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMUL,
        S_FACC,
        S_FSIG,
        S_GDER,
        S_GERR,
        S_GRATE,
        S_GSTORE,
        S_WMUL,
        S_WUPD,
        S_LOAD
    } t_state;

    typedef enum logic [2:0] {
        MSEL_FWD,
        MSEL_DERIV,
        MSEL_ERR,
        MSEL_RATE,
        MSEL_GRAD
    } t_msel;

    typedef struct packed {
        logic  in_ready;
        t_msel msel;
        logic  acc_en;
        logic  sig_en;
        logic  grad_en;
        logic  wupd_en;
        logic  load_en;
        logic  advance;
    } t_ctrl;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] cmd;
        logic       idx_zero;
        logic       last;
        logic       out_free;
    } t_stat;

    typedef logic [12:0] t_sig_rom [SIG_DEPTH];

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // restoring division, elaboration use only
    function automatic longint unsigned sig_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [12:0] sig_entry(input int i);
        longint x;
        longint unsigned a;
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint sum;
        longint unsigned t;
        longint unsigned den;
        longint unsigned res;
        logic stop;
        int k;
        x    = (longint'(8 * (2 * i + 1)) * ONE_Q30) / SIG_DEPTH - 8 * ONE_Q30;
        a    = (x < 0) ? longint'(-x) : longint'(x);
        n    = a >> 30;
        f    = a & longint'(ONE_Q30 - 1);
        term = longint'(ONE_Q30);
        sum  = ONE_Q30;
        stop = 1'b0;
        for (k = 1; k <= 40; k++) begin
            if (!stop) begin
                term = sig_udiv((term * f) >> 30, longint'(k));
                if (term == 0) begin
                    stop = 1'b1;
                end else if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        t = (sum < 0) ? 64'd0 : longint'(sum);
        for (k = 0; k < 8; k++) begin
            if (longint'(k) < n) begin
                t = (t * longint'(E1_Q30)) >> 30;
            end
        end
        den = longint'(ONE_Q30) + t;
        if (x >= 0) begin
            res = sig_udiv((64'd1 << 42) + (den >> 1), den);
        end else begin
            res = sig_udiv(t * 64'd4096 + (den >> 1), den);
        end
        return res[12:0];
    endfunction

    function automatic t_sig_rom sig_build();
        t_sig_rom rom;
        int i;
        for (i = 0; i < SIG_DEPTH; i++) begin
            rom[i] = sig_entry(i);
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_TABLE = sig_build();

endpackage

`default_nettype wire

/* rtl/core/sigmoid_neuron_sgd_top.sv */
// Single sigmoid neuron, Q4.12 weights and bias, trained by gradient descent.
// One item is handled at a time through one shared 33x17 multiplier: a forward
// element runs multiply, accumulate and on the last a sigmoid step that waits
// for the result slot; training: the gradient chain of three multiplies on a
// run's first element, then multiply and update; load: a load step. Results sit
// in an output register so a new item may enter while one waits for transfer.
// depends on sns_pkg, sns_mul, sns_fsm
`default_nettype none

module sigmoid_neuron_sgd_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [15:0] i_value,
    input  wire logic signed [15:0] i_error_or_target,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [12:0]             o_activation,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_learning_rate
);

    localparam int IW = sns_pkg::IDX_W;

    sns_pkg::t_ctrl ctrl;
    sns_pkg::t_stat stat;

    logic [15:0]               r_lr;
    logic [2:0]                r_cmd;
    logic signed [15:0]        r_value;
    logic signed [15:0]        r_eot;
    logic                      r_last;
    logic signed [15:0]        r_wmem [sns_pkg::NUM_INPUTS];
    logic signed [15:0]        r_bias;
    logic [12:0]               r_last_out;
    logic [IW-1:0]             r_idx;
    logic signed [39:0]        r_acc;
    logic signed [31:0]        r_grad;
    logic                      r_out_valid;
    logic [12:0]               r_act;

    logic                      accept;
    logic signed [15:0]        w_rd;
    logic signed [32:0]        mul_a;
    logic signed [16:0]        mul_b;
    logic signed [49:0]        prod;
    logic signed [16:0]        err;
    logic signed [40:0]        acc_sum;
    logic signed [39:0]        acc_sat;
    logic signed [28:0]        z_sum;
    logic signed [15:0]        z16;
    logic [15:0]               z_off;
    logic [sns_pkg::SIG_IDX_W-1:0] ti;
    logic signed [49:0]        wr_sum;
    logic signed [22:0]        w_diff;
    logic signed [32:0]        b_sum;
    logic signed [17:0]        b_diff;

    assign accept      = i_valid && ctrl.in_ready;
    assign o_ready     = ctrl.in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_activation = r_act;

    assign stat = '{in_valid: i_valid,
                    cmd: (ctrl.in_ready ? i_cmd : r_cmd),
                    idx_zero: (r_idx == '0),
                    last: r_last,
                    out_free: (!r_out_valid || i_ready)};

    sns_fsm u_fsm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ctrl (ctrl)
    );

    assign w_rd = r_wmem[r_idx];

    assign err = (r_cmd == sns_pkg::CMD_TRAIN_ERR) ? {r_eot[15], r_eot}
               : $signed({4'b0, r_last_out}) - {r_eot[15], r_eot};

    always_comb begin
        case (ctrl.msel)
            sns_pkg::MSEL_DERIV: begin
                mul_a = $signed({20'b0, r_last_out});
                mul_b = $signed({4'b0, sns_pkg::ONE_Q12 - r_last_out});
            end
            sns_pkg::MSEL_ERR: begin
                mul_a = $signed({22'b0, prod[22:12]});
                mul_b = err;
            end
            sns_pkg::MSEL_RATE: begin
                mul_a = $signed({17'b0, r_lr});
                mul_b = prod[28:12];
            end
            sns_pkg::MSEL_GRAD: begin
                mul_a = {r_grad[31], r_grad};
                mul_b = {r_value[15], r_value};
            end
            default: begin
                mul_a = {{17{w_rd[15]}}, w_rd};
                mul_b = {r_value[15], r_value};
            end
        endcase
    end

    sns_mul u_mul (
        .i_clk(i_clk),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (prod)
    );

    // forward accumulate with saturation
    assign acc_sum = {r_acc[39], r_acc} + {{9{prod[31]}}, prod[31:0]};
    always_comb begin
        if (acc_sum[40] != acc_sum[39]) begin
            acc_sat = acc_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        end else begin
            acc_sat = acc_sum[39:0];
        end
    end

    // sigmoid table index
    assign z_sum = {r_acc[39], r_acc[39:12]} + {{13{r_bias[15]}}, r_bias};
    assign z16   = sns_pkg::sat16(32'(z_sum));
    assign z_off = {~z16[15], z16[14:0]};
    assign ti    = z_off[15 -: sns_pkg::SIG_IDX_W];

    // weight and bias updates, rounded
    assign wr_sum = prod + (50'sd1 <<< 27);
    assign w_diff = {{7{w_rd[15]}}, w_rd} - {wr_sum[49], wr_sum[49:28]};
    assign b_sum  = {r_grad[31], r_grad} + 33'sd32768;
    assign b_diff = {{2{r_bias[15]}}, r_bias} - {b_sum[32], b_sum[32:16]};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
            r_eot   <= i_error_or_target;
            r_last  <= i_last;
        end
        if (ctrl.sig_en) begin
            r_act <= sns_pkg::SIG_TABLE[ti];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wupd_en) begin
            r_wmem[r_idx] <= sns_pkg::sat16(32'(w_diff));
        end else if (ctrl.load_en && r_cmd == sns_pkg::CMD_LOAD_W) begin
            r_wmem[r_idx] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr        <= 16'd655;
            r_bias      <= '0;
            r_last_out  <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_grad      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lr <= i_cfg_learning_rate;
            end
            if (ctrl.grad_en) begin
                r_grad <= prod[31:0];
            end
            if (ctrl.acc_en) begin
                r_acc <= acc_sat;
            end
            if (ctrl.sig_en) begin
                r_last_out  <= sns_pkg::SIG_TABLE[ti];
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ctrl.wupd_en && r_last) begin
                r_bias <= sns_pkg::sat16(32'(b_diff));
            end else if (ctrl.load_en && r_cmd == sns_pkg::CMD_LOAD_B) begin
                r_bias <= r_value;
            end
            if (ctrl.advance) begin
                if (r_last) begin
                    r_idx <= '0;
                    r_acc <= '0;
                end else if (32'(r_idx) == sns_pkg::NUM_INPUTS - 1) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sns_mul.sv */
// shared signed multiplier with registered product
// depends on nothing beyond its ports
`default_nettype none

module sns_mul (
    input  wire logic                i_clk,
    input  wire logic signed [32:0]  i_a,
    input  wire logic signed [16:0]  i_b,
    output logic signed [49:0]       o_p
);

    logic signed [49:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/core/sns_fsm.sv */
// sequencer for the shared multiplier: forward, gradient, update and load steps
// depends on sns_pkg
`default_nettype none

module sns_fsm (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sns_pkg::t_stat i_stat,
    output sns_pkg::t_ctrl      o_ctrl
);

    sns_pkg::t_state r_state;
    sns_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sns_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sns_pkg::S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.cmd == sns_pkg::CMD_FWD) begin
                        n_state = sns_pkg::S_FMUL;
                    end else if (i_stat.cmd == sns_pkg::CMD_TRAIN_ERR ||
                                 i_stat.cmd == sns_pkg::CMD_TRAIN_TGT) begin
                        n_state = i_stat.idx_zero ? sns_pkg::S_GDER : sns_pkg::S_WMUL;
                    end else begin
                        n_state = sns_pkg::S_LOAD;
                    end
                end
            end
            sns_pkg::S_FMUL:   n_state = sns_pkg::S_FACC;
            sns_pkg::S_FACC:   n_state = i_stat.last ? sns_pkg::S_FSIG : sns_pkg::S_IDLE;
            sns_pkg::S_FSIG: begin
                if (i_stat.out_free) begin
                    n_state = sns_pkg::S_IDLE;
                end
            end
            sns_pkg::S_GDER:   n_state = sns_pkg::S_GERR;
            sns_pkg::S_GERR:   n_state = sns_pkg::S_GRATE;
            sns_pkg::S_GRATE:  n_state = sns_pkg::S_GSTORE;
            sns_pkg::S_GSTORE: n_state = sns_pkg::S_WMUL;
            sns_pkg::S_WMUL:   n_state = sns_pkg::S_WUPD;
            sns_pkg::S_WUPD:   n_state = sns_pkg::S_IDLE;
            sns_pkg::S_LOAD:   n_state = sns_pkg::S_IDLE;
            default:           n_state = sns_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '{in_ready: 1'b0, msel: sns_pkg::MSEL_FWD, acc_en: 1'b0, sig_en: 1'b0,
                   grad_en: 1'b0, wupd_en: 1'b0, load_en: 1'b0, advance: 1'b0};
        case (r_state)
            sns_pkg::S_IDLE:  o_ctrl.in_ready = 1'b1;
            sns_pkg::S_FMUL:  o_ctrl.msel = sns_pkg::MSEL_FWD;
            sns_pkg::S_FACC: begin
                o_ctrl.acc_en  = 1'b1;
                o_ctrl.advance = !i_stat.last;
            end
            sns_pkg::S_FSIG: begin
                o_ctrl.sig_en  = i_stat.out_free;
                o_ctrl.advance = i_stat.out_free;
            end
            sns_pkg::S_GDER:   o_ctrl.msel = sns_pkg::MSEL_DERIV;
            sns_pkg::S_GERR:   o_ctrl.msel = sns_pkg::MSEL_ERR;
            sns_pkg::S_GRATE:  o_ctrl.msel = sns_pkg::MSEL_RATE;
            sns_pkg::S_GSTORE: o_ctrl.grad_en = 1'b1;
            sns_pkg::S_WMUL:   o_ctrl.msel = sns_pkg::MSEL_GRAD;
            sns_pkg::S_WUPD: begin
                o_ctrl.wupd_en = 1'b1;
                o_ctrl.advance = 1'b1;
            end
            sns_pkg::S_LOAD: begin
                o_ctrl.load_en = 1'b1;
                o_ctrl.advance = (i_stat.cmd == sns_pkg::CMD_LOAD_W);
            end
            default: o_ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/sns_checker.sv */
// port-level checks for the sigmoid neuron, bound to the top level
// depends on sigmoid_neuron_sgd_top_assert.svh
`default_nettype none

`include "sigmoid_neuron_sgd_top_assert.svh"

module sns_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [12:0] o_activation
);

    `SNS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_activation), "result changed while stalled")
    `SNS_ASSERT(a_act_range, i_clk, i_rst_n, o_valid |-> o_activation <= 13'd4096, "activation above one")
    `SNS_ASSERT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "input taken on consecutive cycles")
    `SNS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result pending after reset")

endmodule

bind sigmoid_neuron_sgd_top sns_checker u_sns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_activation(o_activation)
);

`default_nettype wire
